// ===== rtl/rls_pkg.sv =====
// ----------------------------------------------------------------------------
// rls_pkg: shared types, constants and arithmetic helpers
// Cell data/control structs, divider request, register indexes, rounding.
// ----------------------------------------------------------------------------
package rls_pkg;

   localparam int ORDER   = 16;
   localparam int IDX_W   = (ORDER > 1) ? $clog2(ORDER) : 1;
   localparam int P_DEPTH = ORDER * ORDER;
   localparam int P_AW    = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
   // 32x16 products summed over ORDER terms
   localparam int ACC_W   = 48 + IDX_W;
   // denominator: rounded tap-by-v sum plus rounded lambda, always positive
   localparam int DEN_W   = ACC_W - 15;
   localparam int NUM_W   = 62;
   localparam int Q_W     = 31;
   localparam int CSR_W   = 31;

   localparam logic [CSR_W-1:0] LAMBDA_RESET = 31'd1063004406;
   localparam logic [CSR_W-1:0] DELTA_RESET  = 31'd16777216;

   typedef enum logic [2:0] {
      CSR_FORGETTING_FACTOR = 3'd0,
      CSR_INIT_DIAGONAL     = 3'd1,
      CSR_ADAPT_ENABLE      = 3'd2,
      CSR_APPLY_ENABLE      = 3'd3,
      CSR_ERROR_INPUT_MODE  = 3'd4,
      CSR_ERROR_OUTPUT_MODE = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0]      tap;
      logic signed [15:0]      xq;
      logic signed [31:0]      w;
      logic signed [ACC_W-1:0] racc;
      logic signed [31:0]      v;
      logic signed [31:0]      k;
   } cell_data_type;

   typedef struct packed {
      logic tap_shift;
      logic tap_rot;
      logic xq_load;
      logic xq_rot;
      logic w_clr;
      logic w_rot;
      logic racc_clr;
      logic racc_rot;
      logic v_rot;
      logic k_rot;
   } cell_ctl_type;

   typedef struct packed {
      logic             start;
      logic             neg;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] dvs;
   } div_req_type;

   // round half up by 2^s: floor((v + 2^(s-1)) / 2^s)
   function automatic logic signed [64:0] rnd64(input logic signed [63:0] v,
                                                input int unsigned s);
      logic signed [64:0] t;
      t = $signed({v[63], v}) + (65'sd1 <<< (s - 1));
      return t >>> s;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
      logic signed [31:0] r;
      if (v > 65'sd2147483647) r = 32'sh7FFF_FFFF;
      else if (v < -65'sd2147483648) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [64:0] v);
      logic signed [15:0] r;
      if (v > 65'sd32767) r = 16'sh7FFF;
      else if (v < -65'sd32768) r = 16'sh8000;
      else r = v[15:0];
      return r;
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      return v[31] ? 32'(-v) : 32'(v);
   endfunction

endpackage

// ===== rtl/rls_ram.sv =====
// ----------------------------------------------------------------------------
// rls_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rls_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rls_cell.sv =====
// ----------------------------------------------------------------------------
// rls_cell: one tap cell of the filter chain
// Holds tap, tap copy, weight, column accumulator, v and gain for one index;
// fields rotate toward cell 0, taps shift in at cell 0 and move away from it.
// ----------------------------------------------------------------------------
module rls_cell import rls_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cell_ctl_type       ctl,
   input  cell_data_type      nxt,
   input  logic signed [15:0] prv_tap,
   output cell_data_type      cur
);

   logic signed [15:0]      tap_ff;
   logic signed [15:0]      xq_ff;
   logic signed [31:0]      w_ff;
   logic signed [ACC_W-1:0] racc_ff;
   logic signed [31:0]      v_ff;
   logic signed [31:0]      k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff <= '0;
         w_ff   <= '0;
      end else begin
         if (ctl.tap_shift) begin
            tap_ff <= prv_tap;
         end else if (ctl.tap_rot) begin
            tap_ff <= nxt.tap;
         end
         if (ctl.w_clr) begin
            w_ff <= '0;
         end else if (ctl.w_rot) begin
            w_ff <= nxt.w;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.xq_load) begin
         xq_ff <= tap_ff;
      end else if (ctl.xq_rot) begin
         xq_ff <= nxt.xq;
      end
      if (ctl.racc_clr) begin
         racc_ff <= '0;
      end else if (ctl.racc_rot) begin
         racc_ff <= nxt.racc;
      end
      if (ctl.v_rot) begin
         v_ff <= nxt.v;
      end
      if (ctl.k_rot) begin
         k_ff <= nxt.k;
      end
   end

   always_comb begin
      cur.tap  = tap_ff;
      cur.xq   = xq_ff;
      cur.w    = w_ff;
      cur.racc = racc_ff;
      cur.v    = v_ff;
      cur.k    = k_ff;
   end

endmodule

// ===== rtl/rls_div.sv =====
// ----------------------------------------------------------------------------
// rls_div: serial saturating divider
// Truncating signed quotient of a magnitude and sign by a positive divisor,
// saturated to 32 bits; one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rls_div import rls_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  div_req_type        req,
   output logic               done,
   output logic signed [31:0] quot
);

   typedef enum logic {D_IDLE, D_RUN} div_state_type;

   div_state_type      state_ff;
   logic               done_ff;
   logic               neg_ff;
   logic               sat_ff;
   logic [DEN_W-1:0]   dvs_ff;
   logic [DEN_W-1:0]   rem_ff;
   logic [Q_W-1:0]     low_ff;
   logic [Q_W-1:0]     quo_ff;
   logic [4:0]         cnt_ff;

   logic [DEN_W-1:0]   hi;
   logic [DEN_W:0]     trial;
   logic [DEN_W:0]     diff;
   logic               ge;

   assign hi    = DEN_W'(req.num[NUM_W-1:Q_W]);
   assign trial = {rem_ff, low_ff[Q_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            D_IDLE: begin
               if (req.start) begin
                  neg_ff <= req.neg;
                  dvs_ff <= req.dvs;
                  rem_ff <= hi;
                  low_ff <= req.num[Q_W-1:0];
                  quo_ff <= '0;
                  cnt_ff <= '0;
                  // quotient of 2^31 or more saturates either way
                  if (hi >= req.dvs) begin
                     sat_ff  <= 1'b1;
                     done_ff <= 1'b1;
                  end else begin
                     sat_ff   <= 1'b0;
                     state_ff <= D_RUN;
                  end
               end
            end
            D_RUN: begin
               rem_ff <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
               quo_ff <= {quo_ff[Q_W-2:0], ge};
               low_ff <= {low_ff[Q_W-2:0], 1'b0};
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(Q_W - 1)) begin
                  done_ff  <= 1'b1;
                  state_ff <= D_IDLE;
               end
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   always_comb begin
      if (sat_ff) begin
         quot = neg_ff ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         quot = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      end
   end

   assign done = done_ff;

endmodule

// ===== rtl/rls_adaptive_filter.sv =====
// ----------------------------------------------------------------------------
// rls_adaptive_filter: exponentially weighted RLS adaptive FIR
// Per-sample RLS update over a chain of tap cells, P held in a RAM.
// ----------------------------------------------------------------------------
// Idle mode (apply and adapt off) gives a zero output; apply only runs the output MAC.
// Adapting with ORDER 16, the sample time is set by the serial divider:
// 16 gain divides and 256 P updates, one divide each.
// A restart adds a P init sweep over all 256 entries. After reset the same sweep loads
// the reset diagonal; no transaction is taken until it finishes.
// ----------------------------------------------------------------------------
module rls_adaptive_filter import rls_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [31:0]      req_tdata,   // [15:0] reference_sample, [31:16] desired_sample
   input  logic             req_tuser,   // [0] restart
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [15:0]      rsp_tdata,   // [15:0] filter_output
   input  logic             csr_write_enable,
   input  logic [2:0]       csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   typedef enum logic [4:0] {
      S_CLR, S_IDLE, S_DISP, S_Y, S_YEND, S_V, S_VTAIL, S_DEN, S_DENEND,
      S_GSTART, S_GWAIT, S_WMUL, S_WADD, S_PRD, S_PMUL, S_PSUB, S_PDIV, S_FIN
   } state_type;

   state_type               state_ff;
   logic [CSR_W-1:0]        lambda_ff;
   logic [CSR_W-1:0]        delta_ff;
   logic                    adapt_ff;
   logic                    apply_ff;
   logic                    eim_ff;
   logic                    eom_ff;
   logic                    item_ff;
   logic [CSR_W-1:0]        clr_val_ff;
   logic [IDX_W-1:0]        row_ff;
   logic [IDX_W-1:0]        col_ff;
   logic [IDX_W-1:0]        crow_ff;
   logic [IDX_W-1:0]        ccol_ff;
   logic                    rdv_ff;
   logic                    iss_end_ff;
   logic [IDX_W-1:0]        cnt_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] vacc_ff;
   logic signed [ACC_W-1:0] vfin_ff;
   logic                    vpush_ff;
   logic signed [15:0]      d_ff;
   logic signed [15:0]      res_ff;
   logic signed [31:0]      eps_ff;
   logic [DEN_W-1:0]        den_ff;
   logic signed [31:0]      r_ff;
   logic signed [31:0]      p_ff;
   logic signed [63:0]      prod_ff;
   logic                    rsp_valid_ff;
   logic [15:0]             rsp_data_ff;

   cell_data_type           cell_q [ORDER];
   cell_data_type           head;
   cell_data_type           tail;
   cell_ctl_type            ctl;
   div_req_type             div_req;
   logic                    div_done;
   logic signed [31:0]      div_q;

   logic                    ram_we;
   logic [P_AW-1:0]         ram_waddr;
   logic [31:0]             ram_wdata;
   logic [P_AW-1:0]         ram_raddr;
   logic [31:0]             ram_rd;

   logic                    accept;
   logic                    row_last;
   logic                    col_last;
   logic                    cnt_last;
   logic [P_AW-1:0]         cur_addr;
   logic [CSR_W-1:0]        lam_eff;
   logic signed [31:0]      mac_b;
   logic signed [47:0]      mac_prod;
   logic signed [47:0]      prodv;
   logic signed [47:0]      prodr;
   logic signed [64:0]      y_w;
   logic signed [64:0]      res_w;
   logic signed [64:0]      eps_w;
   logic signed [64:0]      den_w;
   logic signed [31:0]      diff32;
   logic signed [31:0]      w_upd;

   assign accept   = req_tvalid && req_tready;
   assign head     = cell_q[0];
   assign row_last = row_ff == IDX_W'(ORDER - 1);
   assign col_last = col_ff == IDX_W'(ORDER - 1);
   assign cnt_last = cnt_ff == IDX_W'(ORDER - 1);
   assign cur_addr = P_AW'(row_ff) * P_AW'(ORDER) + P_AW'(col_ff);
   assign lam_eff  = (lambda_ff == '0) ? CSR_W'(1) : lambda_ff;

   // shared MAC for the output sum and the x-by-v sum
   assign mac_b    = (state_ff == S_DEN) ? head.v : head.w;
   assign mac_prod = mac_b * head.tap;
   assign prodv    = $signed(ram_rd) * head.tap;
   assign prodr    = $signed(ram_rd) * head.xq;

   assign y_w   = rnd64(64'(acc_ff), 24);
   assign res_w = eom_ff ? (65'(d_ff) - y_w) : y_w;
   assign eps_w = eim_ff ? 65'(d_ff) : (65'(d_ff) - y_w);
   assign den_w = $signed({34'd0, CSR_W'((32'(lam_eff) + 32'd32) >> 6)})
                  + rnd64(64'(acc_ff), 15);

   assign diff32 = sat32(65'(p_ff) - rnd64(prod_ff, 24));
   assign w_upd  = sat32(65'(head.w) + rnd64(prod_ff, 15));

   // ring tail: head value comes back around unless updated
   always_comb begin
      tail      = head;
      tail.w    = (state_ff == S_WADD) ? w_upd : head.w;
      tail.racc = (state_ff == S_V) ? (head.racc + ACC_W'(prodr)) : head.racc;
      tail.v    = vpush_ff ? sat32(rnd64(64'(vfin_ff), 15)) : head.v;
      tail.k    = (state_ff == S_GWAIT) ? div_q : head.k;
   end

   always_comb begin
      ctl = '0;
      if (accept) begin
         ctl.tap_shift = 1'b1;
         ctl.w_clr     = req_tuser;
      end
      if (vpush_ff) begin
         ctl.v_rot = 1'b1;
      end
      case (state_ff)
         S_Y: begin
            ctl.tap_rot = 1'b1;
            ctl.w_rot   = 1'b1;
         end
         S_YEND: begin
            ctl.racc_clr = adapt_ff;
            ctl.xq_load  = adapt_ff;
         end
         S_V: begin
            if (rdv_ff) begin
               ctl.tap_rot  = 1'b1;
               ctl.racc_rot = 1'b1;
               ctl.xq_rot   = ccol_ff == IDX_W'(ORDER - 1);
            end
         end
         S_DEN: begin
            ctl.tap_rot = 1'b1;
            ctl.v_rot   = 1'b1;
         end
         S_GWAIT: begin
            ctl.k_rot = div_done;
            ctl.v_rot = div_done;
         end
         S_WADD: begin
            ctl.w_rot = 1'b1;
            ctl.k_rot = 1'b1;
         end
         S_PDIV: begin
            ctl.racc_rot = div_done;
            ctl.k_rot    = div_done && col_last;
         end
         default: ;
      endcase
   end

   always_comb begin
      div_req       = '0;
      div_req.start = (state_ff == S_GSTART) || (state_ff == S_PSUB);
      if (state_ff == S_GSTART) begin
         div_req.neg = head.v[31];
         div_req.num = NUM_W'(mag32(head.v)) << 24;
         div_req.dvs = den_ff;
      end else begin
         div_req.neg = diff32[31];
         div_req.num = NUM_W'(mag32(diff32)) << 30;
         div_req.dvs = DEN_W'(lam_eff);
      end
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_wdata = div_q;
      ram_waddr = cur_addr;
      ram_raddr = cur_addr;
      if (state_ff == S_CLR) begin
         ram_we    = 1'b1;
         ram_wdata = (row_ff == col_ff) ? {1'b0, clr_val_ff} : 32'd0;
      end else if (state_ff == S_PDIV) begin
         ram_we = div_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         lambda_ff    <= LAMBDA_RESET;
         delta_ff     <= DELTA_RESET;
         adapt_ff     <= 1'b0;
         apply_ff     <= 1'b0;
         eim_ff       <= 1'b0;
         eom_ff       <= 1'b0;
         item_ff      <= 1'b0;
         clr_val_ff   <= DELTA_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
         rdv_ff       <= 1'b0;
         vpush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_FORGETTING_FACTOR: lambda_ff <= csr_wdata;
               CSR_INIT_DIAGONAL:     delta_ff  <= csr_wdata;
               CSR_ADAPT_ENABLE:      adapt_ff  <= csr_wdata[0];
               CSR_APPLY_ENABLE:      apply_ff  <= csr_wdata[0];
               CSR_ERROR_INPUT_MODE:  eim_ff    <= csr_wdata[0];
               CSR_ERROR_OUTPUT_MODE: eom_ff    <= csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         vpush_ff <= 1'b0;
         rdv_ff   <= 1'b0;
         case (state_ff)
            S_CLR: begin
               col_ff <= col_ff + IDX_W'(1);
               if (col_last) begin
                  col_ff <= '0;
                  row_ff <= row_ff + IDX_W'(1);
                  if (row_last) begin
                     row_ff   <= '0;
                     state_ff <= item_ff ? S_DISP : S_IDLE;
                  end
               end
            end
            S_IDLE: begin
               if (accept) begin
                  d_ff    <= req_tdata[31:16];
                  item_ff <= 1'b1;
                  if (req_tuser) begin
                     clr_val_ff <= delta_ff;
                     row_ff     <= '0;
                     col_ff     <= '0;
                     state_ff   <= S_CLR;
                  end else begin
                     state_ff <= S_DISP;
                  end
               end
            end
            S_DISP: begin
               acc_ff <= '0;
               cnt_ff <= '0;
               if (apply_ff || adapt_ff) begin
                  state_ff <= S_Y;
               end else begin
                  res_ff   <= '0;
                  state_ff <= S_FIN;
               end
            end
            S_Y: begin
               acc_ff <= acc_ff + ACC_W'(mac_prod);
               cnt_ff <= cnt_ff + IDX_W'(1);
               if (cnt_last) begin
                  state_ff <= S_YEND;
               end
            end
            S_YEND: begin
               res_ff     <= sat16(res_w);
               eps_ff     <= sat32(eps_w);
               row_ff     <= '0;
               col_ff     <= '0;
               iss_end_ff <= 1'b0;
               vacc_ff    <= '0;
               state_ff   <= adapt_ff ? S_V : S_FIN;
            end
            S_V: begin
               // each read is issued in the cycle before its data is accumulated
               if (!iss_end_ff) begin
                  rdv_ff <= 1'b1;
                  col_ff <= col_ff + IDX_W'(1);
                  if (col_last) begin
                     col_ff <= '0;
                     row_ff <= row_ff + IDX_W'(1);
                     if (row_last) begin
                        row_ff     <= '0;
                        iss_end_ff <= 1'b1;
                     end
                  end
               end
               crow_ff <= row_ff;
               ccol_ff <= col_ff;
               if (rdv_ff) begin
                  if (ccol_ff == IDX_W'(ORDER - 1)) begin
                     vfin_ff  <= vacc_ff + ACC_W'(prodv);
                     vpush_ff <= 1'b1;
                     vacc_ff  <= '0;
                     if (crow_ff == IDX_W'(ORDER - 1)) begin
                        state_ff <= S_VTAIL;
                     end
                  end else begin
                     vacc_ff <= vacc_ff + ACC_W'(prodv);
                  end
               end
            end
            S_VTAIL: begin
               acc_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= S_DEN;
            end
            S_DEN: begin
               acc_ff <= acc_ff + ACC_W'(mac_prod);
               cnt_ff <= cnt_ff + IDX_W'(1);
               if (cnt_last) begin
                  state_ff <= S_DENEND;
               end
            end
            S_DENEND: begin
               den_ff   <= (den_w < 65'sd1) ? DEN_W'(1) : den_w[DEN_W-1:0];
               cnt_ff   <= '0;
               state_ff <= S_GSTART;
            end
            S_GSTART: begin
               state_ff <= S_GWAIT;
            end
            S_GWAIT: begin
               if (div_done) begin
                  cnt_ff   <= cnt_ff + IDX_W'(1);
                  state_ff <= S_GSTART;
                  if (cnt_last) begin
                     cnt_ff   <= '0;
                     state_ff <= S_WMUL;
                  end
               end
            end
            S_WMUL: begin
               prod_ff  <= 64'(eps_ff * head.k);
               state_ff <= S_WADD;
            end
            S_WADD: begin
               cnt_ff   <= cnt_ff + IDX_W'(1);
               state_ff <= S_WMUL;
               if (cnt_last) begin
                  row_ff   <= '0;
                  col_ff   <= '0;
                  state_ff <= S_PRD;
               end
            end
            S_PRD: begin
               r_ff     <= sat32(rnd64(64'(head.racc), 15));
               state_ff <= S_PMUL;
            end
            S_PMUL: begin
               p_ff     <= $signed(ram_rd);
               prod_ff  <= 64'(head.k * r_ff);
               state_ff <= S_PSUB;
            end
            S_PSUB: begin
               state_ff <= S_PDIV;
            end
            S_PDIV: begin
               if (div_done) begin
                  state_ff <= S_PRD;
                  col_ff   <= col_ff + IDX_W'(1);
                  if (col_last) begin
                     col_ff <= '0;
                     row_ff <= row_ff + IDX_W'(1);
                     if (row_last) begin
                        row_ff   <= '0;
                        state_ff <= S_FIN;
                     end
                  end
               end
            end
            S_FIN: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= res_ff;
                  item_ff      <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   genvar c;
   generate
      for (c = 0; c < ORDER; c++) begin : g_cell
         cell_data_type      nxt;
         logic signed [15:0] prv;
         if (c == ORDER - 1) begin : g_tail
            assign nxt = tail;
         end else begin : g_mid
            assign nxt = cell_q[c+1];
         end
         if (c == 0) begin : g_first
            assign prv = req_tdata[15:0];
         end else begin : g_rest
            assign prv = cell_q[c-1].tap;
         end
         rls_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .ctl     (ctl),
            .nxt     (nxt),
            .prv_tap (prv),
            .cur     (cell_q[c])
         );
      end
   endgenerate

   rls_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .done  (div_done),
      .quot  (div_q)
   );

   rls_ram #(
      .WIDTH (32),
      .DEPTH (P_DEPTH)
   ) u_p_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rd)
   );

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
